### rtl/nchq_pkg.sv
`timescale 1ns / 1ps

package nchq_pkg;

   localparam int NUM_CENTERS_DEF = 4;

   localparam int COORD_W = 16;
   localparam int IDX_W   = 4;
   localparam int DIST_W  = 33;
   localparam int SQ_W    = 32;
   localparam int COUNT_W = 8;

   // larger than any reachable distance, so the first cell always takes over
   localparam logic [DIST_W-1:0] DIST_INF = '1;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUANT = 1'b1;

   localparam logic KIND_NEAREST = 1'b0;
   localparam logic KIND_BIN     = 1'b1;

   // running minimum handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic [DIST_W-1:0] best;
      logic [IDX_W-1:0]  win;
   } chain_tok_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic             load_en;
      logic [IDX_W-1:0] slot;
      logic             start;
      logic             inc_en;
      logic [IDX_W-1:0] inc_idx;
      logic             shift_en;
   } cell_ctl_type;

endpackage

### rtl/nchq_cell.sv
`timescale 1ns / 1ps

module nchq_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  nchq_pkg::cell_ctl_type              ctl,
   input  logic signed [nchq_pkg::COORD_W-1:0] coord_first,
   input  logic signed [nchq_pkg::COORD_W-1:0] coord_second,
   input  nchq_pkg::chain_tok_type             tok_in,
   output nchq_pkg::chain_tok_type             tok_out,
   input  logic [nchq_pkg::COUNT_W-1:0]        count_next,
   output logic [nchq_pkg::COUNT_W-1:0]        count_out
);

   localparam logic [nchq_pkg::IDX_W-1:0] MY_IDX = nchq_pkg::IDX_W'(CELL_IDX);

   // center: [15:0] first coordinate, [31:16] second; no reset, undefined until loaded
   logic [2*nchq_pkg::COORD_W-1:0] center_ff;
   logic [nchq_pkg::SQ_W-1:0]      sq_first_ff, sq_second_ff;
   logic [nchq_pkg::SQ_W-1:0]      sq_first_in, sq_second_in;
   logic [nchq_pkg::COUNT_W-1:0]   count_ff, count_in;
   nchq_pkg::chain_tok_type        tok_ff, tok_in_next;

   logic signed [nchq_pkg::COORD_W:0]     diff_first, diff_second;
   logic signed [2*nchq_pkg::COORD_W+1:0] prod_first, prod_second;
   logic [nchq_pkg::DIST_W-1:0]           dist_sum;

   always_comb begin
      diff_first  = {center_ff[nchq_pkg::COORD_W-1], center_ff[nchq_pkg::COORD_W-1:0]}
                  - {coord_first[nchq_pkg::COORD_W-1], coord_first};
      diff_second = {center_ff[2*nchq_pkg::COORD_W-1],
                     center_ff[2*nchq_pkg::COORD_W-1:nchq_pkg::COORD_W]}
                  - {coord_second[nchq_pkg::COORD_W-1], coord_second};
      prod_first  = diff_first * diff_first;
      prod_second = diff_second * diff_second;
      // |diff| <= 65535, so each square fits 32 bits
      sq_first_in  = ctl.start ? prod_first[nchq_pkg::SQ_W-1:0]  : sq_first_ff;
      sq_second_in = ctl.start ? prod_second[nchq_pkg::SQ_W-1:0] : sq_second_ff;
   end

   always_comb begin
      dist_sum = {1'b0, sq_first_ff} + {1'b0, sq_second_ff};
      tok_in_next = tok_in;
      // strict compare keeps the lower index on a tie
      if (tok_in.valid && (dist_sum < tok_in.best)) begin
         tok_in_next.best = dist_sum;
         tok_in_next.win  = MY_IDX;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.shift_en) begin
         count_in = count_next;
      end else if (ctl.inc_en && (ctl.inc_idx == MY_IDX) && (count_ff != '1)) begin
         count_in = count_ff + nchq_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_en && (ctl.slot == MY_IDX)) begin
         center_ff <= {coord_second, coord_first};
      end
      sq_first_ff  <= sq_first_in;
      sq_second_ff <= sq_second_in;
      tok_ff.best  <= tok_in_next.best;
      tok_ff.win   <= tok_in_next.win;
      if (reset) begin
         tok_ff.valid <= 1'b0;
         count_ff     <= '0;
      end else begin
         tok_ff.valid <= tok_in_next.valid;
         count_ff     <= count_in;
      end
   end

   assign tok_out   = tok_ff;
   assign count_out = count_ff;

endmodule

### rtl/nearest_center_quantize_histogram_core.sv
`timescale 1ns / 1ps

// Nearest-center quantizer with a bag-of-words histogram. A row of
// NUM_CENTERS cells each holds one codebook center and one 8-bit bin count.
// A load beat (req_type 0) writes one center; a slot at or above
// NUM_CENTERS is dropped. A descriptor beat broadcasts its coordinates,
// every cell registers its squared distance, and the running minimum then
// walks the row one cell per cycle; the nearest-center result is then
// registered on the outputs, and req_stall holds off the next beat until
// it has been. On the last descriptor of a vector the counts shift out of
// the row one per cycle unless rsp_stall holds them, which also clears
// them, and the next beat waits for the last bin. Every center must be
// loaded before the first descriptor; an unloaded center gives undefined results.
// rsp_last_of_run marks the final result beat caused by a request beat.
module nearest_center_quantize_histogram_core #(
   parameter int NUM_CENTERS = nchq_pkg::NUM_CENTERS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic [nchq_pkg::IDX_W-1:0]           req_center_slot,
   input  logic signed [nchq_pkg::COORD_W-1:0]  req_coord_first,
   input  logic signed [nchq_pkg::COORD_W-1:0]  req_coord_second,
   input  logic                                 req_last_of_vector,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_result_kind,
   output logic [nchq_pkg::IDX_W-1:0]           rsp_winner_index,
   output logic [nchq_pkg::DIST_W-1:0]          rsp_best_distance,
   output logic [nchq_pkg::COUNT_W-1:0]         rsp_bin_count,
   output logic                                 rsp_last_of_run
);

   localparam logic [nchq_pkg::IDX_W-1:0] LAST_BIN = nchq_pkg::IDX_W'(NUM_CENTERS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_WIN,
      ST_BINS
   } state_type;

   state_type                     state_ff, state_in;
   logic                          start_ff, start_in;
   logic                          last_ff, last_in;
   logic [nchq_pkg::IDX_W-1:0]    win_ff, win_in;
   logic [nchq_pkg::DIST_W-1:0]   dist_ff, dist_in;
   logic [nchq_pkg::IDX_W-1:0]    bin_idx_ff, bin_idx_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_kind_ff, rsp_kind_in;
   logic [nchq_pkg::IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [nchq_pkg::DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;
   logic [nchq_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          req_accept;
   logic                          slot_free;
   logic                          rsp_load;
   nchq_pkg::cell_ctl_type        ctl;
   nchq_pkg::chain_tok_type       tok [0:NUM_CENTERS];
   logic [nchq_pkg::COUNT_W-1:0]  count_w [0:NUM_CENTERS-1];

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   assign tok[0].valid = start_ff;
   assign tok[0].best  = nchq_pkg::DIST_INF;
   assign tok[0].win   = '0;

   for (genvar j = 0; j < NUM_CENTERS; j++) begin : g_cell
      logic [nchq_pkg::COUNT_W-1:0] count_next;
      if (j == NUM_CENTERS - 1) begin : g_tail
         assign count_next = '0;
      end else begin : g_mid
         assign count_next = count_w[j+1];
      end
      nchq_cell #(
         .CELL_IDX (j)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .coord_first  (req_coord_first),
         .coord_second (req_coord_second),
         .tok_in       (tok[j]),
         .tok_out      (tok[j+1]),
         .count_next   (count_next),
         .count_out    (count_w[j])
      );
   end

   always_comb begin
      state_in     = state_ff;
      start_in     = 1'b0;
      last_in      = last_ff;
      win_in       = win_ff;
      dist_in      = dist_ff;
      bin_idx_in   = bin_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_index_in = rsp_index_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_load     = 1'b0;

      ctl.load_en  = req_accept && (req_type == nchq_pkg::REQ_LOAD);
      ctl.slot     = req_center_slot;
      ctl.start    = req_accept && (req_type == nchq_pkg::REQ_QUANT);
      ctl.inc_en   = 1'b0;
      ctl.inc_idx  = tok[NUM_CENTERS].win;
      ctl.shift_en = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               start_in = 1'b1;
               last_in  = req_last_of_vector;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tok[NUM_CENTERS].valid) begin
               ctl.inc_en = 1'b1;
               win_in     = tok[NUM_CENTERS].win;
               dist_in    = tok[NUM_CENTERS].best;
               state_in   = ST_WIN;
            end
         end
         ST_WIN: begin
            if (slot_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = nchq_pkg::KIND_NEAREST;
               rsp_index_in = win_ff;
               rsp_dist_in  = dist_ff;
               rsp_count_in = '0;
               rsp_last_in  = !last_ff;
               bin_idx_in   = '0;
               state_in     = last_ff ? ST_BINS : ST_IDLE;
            end
         end
         ST_BINS: begin
            if (slot_free) begin
               // bin 0 sits at the head of the row; shifting also clears
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = nchq_pkg::KIND_BIN;
               rsp_index_in = bin_idx_ff;
               rsp_dist_in  = '0;
               rsp_count_in = count_w[0];
               rsp_last_in  = (bin_idx_ff == LAST_BIN);
               ctl.shift_en = 1'b1;
               bin_idx_in   = bin_idx_ff + nchq_pkg::IDX_W'(1);
               if (bin_idx_ff == LAST_BIN) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      win_ff       <= win_in;
      dist_ff      <= dist_in;
      bin_idx_ff   <= bin_idx_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_index_ff <= rsp_index_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_winner_index  = rsp_index_ff;
   assign rsp_best_distance = rsp_dist_ff;
   assign rsp_bin_count     = rsp_count_ff;
   assign rsp_last_of_run   = rsp_last_ff;

   // the minimum only leaves the row while the sequencer waits for it
   a_tail_in_search: assert property (@(posedge clock) disable iff (reset)
      tok[NUM_CENTERS].valid |-> state_ff == ST_SEARCH)
      else $error("chain output outside search");

   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BINS |-> bin_idx_ff <= LAST_BIN)
      else $error("bin index past last center");

   a_win_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && state_ff == ST_WIN) |-> win_ff <= LAST_BIN)
      else $error("winner index out of range");

   // after the last bin beat the whole row has shifted out to zero; the head cell is checked
   a_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && state_ff == ST_BINS && bin_idx_ff == LAST_BIN) |=> count_w[0] == '0)
      else $error("histogram not cleared after dump");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int NUM_CENTERS = nchq_pkg::NUM_CENTERS_DEF;
   localparam int IDX_W   = nchq_pkg::IDX_W;
   localparam int COORD_W = nchq_pkg::COORD_W;
   localparam int DIST_W  = nchq_pkg::DIST_W;
   localparam int COUNT_W = nchq_pkg::COUNT_W;
   localparam logic REQ_LOAD     = nchq_pkg::REQ_LOAD;
   localparam logic REQ_QUANT    = nchq_pkg::REQ_QUANT;
   localparam logic KIND_NEAREST = nchq_pkg::KIND_NEAREST;
   localparam logic KIND_BIN     = nchq_pkg::KIND_BIN;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 4 * NUM_CENTERS + 16;
   localparam int RANDOM_BEATS = 64;
   localparam int SAT_BEATS = 260;

   typedef struct packed {
      logic                      kind;
      logic [IDX_W-1:0]          slot;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      last;
      logic                      chk;      // nearest-center word typed in below
      logic [IDX_W-1:0]          exp_idx;
      logic [DIST_W-1:0]         exp_dist;
   } req_beat_type;

   typedef struct packed {
      logic               kind;
      logic [IDX_W-1:0]   idx;
      logic [DIST_W-1:0]  distance;
      logic [COUNT_W-1:0] count;
      logic               last;
   } rsp_word_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_type;
   logic [IDX_W-1:0]          req_center_slot;
   logic signed [COORD_W-1:0] req_coord_first;
   logic signed [COORD_W-1:0] req_coord_second;
   logic                      req_last_of_vector;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_result_kind;
   logic [IDX_W-1:0]          rsp_winner_index;
   logic [DIST_W-1:0]         rsp_best_distance;
   logic [COUNT_W-1:0]        rsp_bin_count;
   logic                      rsp_last_of_run;

   nearest_center_quantize_histogram_core #(
      .NUM_CENTERS(NUM_CENTERS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_center_slot    (req_center_slot),
      .req_coord_first    (req_coord_first),
      .req_coord_second   (req_coord_second),
      .req_last_of_vector (req_last_of_vector),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_winner_index   (rsp_winner_index),
      .rsp_best_distance  (rsp_best_distance),
      .rsp_bin_count      (rsp_bin_count),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   // predictor state
   logic signed [COORD_W-1:0] center_x [NUM_CENTERS];
   logic signed [COORD_W-1:0] center_y [NUM_CENTERS];
   logic [COUNT_W-1:0]        hist_count [NUM_CENTERS];

   rsp_word_type words_due[$];
   int unsigned  mismatches;
   int unsigned  rsp_words_taken;
   bit           no_idle;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [DIST_W-1:0] sq_dist(input logic signed [COORD_W-1:0] ax,
                                                   input logic signed [COORD_W-1:0] ay,
                                                   input logic signed [COORD_W-1:0] bx,
                                                   input logic signed [COORD_W-1:0] by);
      longint dx;
      longint dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      return DIST_W'(dx * dx + dy * dy);
   endfunction

   // codebook write, or nearest-center search plus histogram update and, on the last beat of a vector, the bin dump
   task automatic quantize_and_count(input req_beat_type b);
      rsp_word_type      w;
      logic [DIST_W-1:0] d;
      logic [DIST_W-1:0] best;
      int                win;
      int                j;
      if (b.kind == REQ_LOAD) begin
         if (int'(b.slot) < NUM_CENTERS) begin
            center_x[b.slot] = b.x;
            center_y[b.slot] = b.y;
         end
         return;
      end
      best = '0;
      win = 0;
      for (j = 0; j < NUM_CENTERS; j++) begin
         d = sq_dist(center_x[j], center_y[j], b.x, b.y);
         if (j == 0 || d < best) begin
            best = d;
            win = j;
         end
      end
      if (hist_count[win] != '1)
         hist_count[win]++;
      w.kind = KIND_NEAREST;
      w.idx = b.chk ? b.exp_idx : IDX_W'(win);
      w.distance = b.chk ? b.exp_dist : best;
      w.count = '0;
      w.last = !b.last;
      words_due.push_back(w);
      if (b.last) begin
         for (j = 0; j < NUM_CENTERS; j++) begin
            w.kind = KIND_BIN;
            w.idx = IDX_W'(j);
            w.distance = '0;
            w.count = hist_count[j];
            w.last = (j == NUM_CENTERS - 1);
            words_due.push_back(w);
            hist_count[j] = '0;
         end
      end
   endtask

   task automatic offer(input req_beat_type b);
      while (!no_idle && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= b.kind;
      req_center_slot    <= b.slot;
      req_coord_first    <= b.x;
      req_coord_second   <= b.y;
      req_last_of_vector <= b.last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      quantize_and_count(b);
   endtask

   function automatic logic signed [COORD_W-1:0] pick_coord(
         input logic signed [COORD_W-1:0] near);
      int unsigned       mode;
      logic [COORD_W-1:0] jit;
      mode = $urandom_range(9);
      jit = COORD_W'($urandom_range(511));
      if (mode < 4)
         return COORD_W'($urandom_range(16'hFFFF));
      if (mode < 6) begin
         case ($urandom_range(3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'shFFFF;
         endcase
      end
      return near + jit - 16'd256;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on result beat %0d, %s: expected %0d, got %0d",
                     rsp_words_taken, name, want, got);
      end
   endtask

   // result side: random stalls, one long hold-off, quiet window
   initial begin : rsp_side
      int unsigned hold_left;
      bit          held;
      hold_left = 0;
      held = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && rsp_words_taken >= 40) begin
            held = 1;
            hold_left = 400;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < 20);
         end
      end
   end

   initial begin : rsp_check
      rsp_word_type want;
      mismatches = 0;
      rsp_words_taken = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            rsp_words_taken++;
            if (words_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat %0d: kind %0d index %0d dist %0d count %0d",
                           rsp_words_taken, rsp_result_kind, rsp_winner_index,
                           rsp_best_distance, rsp_bin_count);
            end else begin
               want = words_due.pop_front();
               check_field("result_kind", 64'(want.kind), 64'(rsp_result_kind));
               check_field("winner_index", 64'(want.idx), 64'(rsp_winner_index));
               check_field("best_distance", 64'(want.distance), 64'(rsp_best_distance));
               check_field("bin_count", 64'(want.count), 64'(rsp_bin_count));
               check_field("last_of_run", 64'(want.last), 64'(rsp_last_of_run));
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stim
      req_beat_type directed_rows [23];
      req_beat_type b;
      int           n;
      int           c;

      // kind, slot, x, y, last, chk, exp_idx, exp_dist
      directed_rows = '{
         '{REQ_LOAD,  4'd0,  16'sh0000, 16'sh0000, 1'b0, 1'b0, 4'd0, 33'd0},
         '{REQ_LOAD,  4'd1,  16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 4'd0, 33'd0},
         '{REQ_LOAD,  4'd2,  16'sh8000, 16'sh8000, 1'b0, 1'b0, 4'd0, 33'd0},
         '{REQ_LOAD,  4'd3,  16'sh0100, 16'shFF00, 1'b0, 1'b0, 4'd0, 33'd0},
         // out-of-range slots are dropped
         '{REQ_LOAD,  4'd15, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 4'd0, 33'd0},
         '{REQ_LOAD,  4'd4,  16'sh0064, 16'sh0064, 1'b0, 1'b0, 4'd0, 33'd0},
         '{REQ_QUANT, 4'd0,  16'sh0000, 16'sh0000, 1'b0, 1'b1, 4'd0, 33'd0},
         '{REQ_QUANT, 4'd15, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1, 4'd1, 33'd0},
         '{REQ_QUANT, 4'd7,  16'sh8000, 16'sh8000, 1'b0, 1'b1, 4'd2, 33'd0},
         '{REQ_QUANT, 4'd0,  16'sh0100, 16'shFF00, 1'b1, 1'b1, 4'd3, 33'd0},
         '{REQ_QUANT, 4'd0,  16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 4'd0, 33'd0},
         // equidistant from centers 0 and 3: lower index wins
         '{REQ_QUANT, 4'd0,  16'sh0080, 16'shFF80, 1'b0, 1'b1, 4'd0, 33'd32768},
         '{REQ_QUANT, 4'd0,  16'shFFFF, 16'sh0001, 1'b1, 1'b1, 4'd0, 33'd2},
         '{REQ_LOAD,  4'd0,  16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 4'd0, 33'd0},
         '{REQ_LOAD,  4'd1,  16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 4'd0, 33'd0},
         '{REQ_LOAD,  4'd2,  16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 4'd0, 33'd0},
         '{REQ_LOAD,  4'd3,  16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 4'd0, 33'd0},
         // all centers tie at the largest distance
         '{REQ_QUANT, 4'd0,  16'sh8000, 16'sh8000, 1'b0, 1'b1, 4'd0, 33'd8589672450},
         '{REQ_QUANT, 4'd0,  16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, 4'd0, 33'd0},
         '{REQ_LOAD,  4'd3,  16'sh7FFF, 16'sh7FFE, 1'b0, 1'b0, 4'd0, 33'd0},
         '{REQ_QUANT, 4'd0,  16'sh7FFF, 16'sh7FFE, 1'b1, 1'b1, 4'd3, 33'd0},
         '{REQ_LOAD,  4'd1,  16'shFFFF, 16'shFFFF, 1'b0, 1'b0, 4'd0, 33'd0},
         '{REQ_LOAD,  4'd2,  16'sh8000, 16'sh0000, 1'b0, 1'b0, 4'd0, 33'd0}
      };

      for (n = 0; n < NUM_CENTERS; n++) begin
         center_x[n] = '0;
         center_y[n] = '0;
         hist_count[n] = '0;
      end
      no_idle = 0;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_type           <= REQ_LOAD;
      req_center_slot    <= '0;
      req_coord_first    <= '0;
      req_coord_second   <= '0;
      req_last_of_vector <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer(directed_rows[i]);

      // every center is loaded from here on
      for (n = 0; n < RANDOM_BEATS; n++) begin
         no_idle = (n >= 30 && n < 60);
         if (n == 20) begin
            while (words_due.size() != 0) begin
               req_valid <= 1'b0;
               @(posedge clock);
            end
         end
         c = $urandom_range(NUM_CENTERS - 1);
         b.kind = ($urandom_range(9) == 0) ? REQ_LOAD : REQ_QUANT;
         b.slot = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(15))
                                           : IDX_W'($urandom_range(NUM_CENTERS - 1));
         b.x = pick_coord(center_x[c]);
         b.y = pick_coord(center_y[c]);
         b.last = ($urandom_range(4) == 0);
         b.chk = 1'b0;
         b.exp_idx = '0;
         b.exp_dist = '0;
         offer(b);
      end
      no_idle = 0;

      // one long vector pinned to center 0 so its bin saturates
      for (n = 0; n < NUM_CENTERS + SAT_BEATS; n++) begin
         b = '0;
         if (n < NUM_CENTERS) begin
            b.kind = REQ_LOAD;
            b.slot = IDX_W'(n);
            b.x = (n == 0) ? 16'sh0000 : ((n == 2) ? -16'sd8192 : 16'sd8192);
            b.y = (n == 0) ? 16'sh0000 : ((n == 3) ? -16'sd8192 : 16'sd8192);
         end else begin
            b.kind = REQ_QUANT;
            b.slot = IDX_W'($urandom_range(15));
            b.x = COORD_W'($urandom_range(128)) - 16'sd64;
            b.y = COORD_W'($urandom_range(128)) - 16'sd64;
            b.last = (n == NUM_CENTERS + SAT_BEATS - 1);
         end
         offer(b);
      end
      req_valid <= 1'b0;

      while (words_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && words_due.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
